[rtl/rrs_pkg.sv]
// Shared types, constants and helpers for the round-robin time-slice scheduler.
// No dependencies; every other file in rtl/ but rrs_ram uses this package.
`default_nettype none

package rrs_pkg;

  // Ready queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned BurstW = 16;
  localparam int unsigned SumW   = 32;

  localparam logic [BurstW-1:0] QuantumReset = BurstW'(10);

  // Operation codes on the func field
  localparam logic FuncAdd      = 1'b0;
  localparam logic FuncDispatch = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_IDLE       = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  // One ready-queue entry
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Counter update request from the sequencer
  typedef struct packed {
    logic              dispatch;
    logic [BurstW-1:0] slice;
  } stats_upd_t;

  // Counter values after the current cycle's update
  typedef struct packed {
    logic [SumW-1:0] elapsed;
    logic [SumW-1:0] dispatches;
  } stats_t;

  // Circular pointer advance, works for any depth
  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p);
    return (p == AddrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

[rtl/rrs_if.sv]
// Valid/ready channel interfaces for request items and result items.
// Depends on rrs_pkg for field widths.
`default_nettype none

interface rrs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [rrs_pkg::IdW-1:0]    task_id;
  logic [rrs_pkg::PrioW-1:0]  task_priority;
  logic [rrs_pkg::BurstW-1:0] burst_length;

  modport source (output valid, func, task_id, task_priority, burst_length, input ready);
  modport sink   (input valid, func, task_id, task_priority, burst_length, output ready);
endinterface

interface rrs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [rrs_pkg::IdW-1:0]    granted_id;
  logic [rrs_pkg::PrioW-1:0]  granted_priority;
  logic [rrs_pkg::BurstW-1:0] slice_length;
  logic [rrs_pkg::BurstW-1:0] burst_left;
  logic [rrs_pkg::SumW-1:0]   elapsed_time;
  logic [rrs_pkg::SumW-1:0]   dispatch_total;

  modport source (output valid, status, granted_id, granted_priority, slice_length,
                  burst_left, elapsed_time, dispatch_total, input ready);
  modport sink   (input valid, status, granted_id, granted_priority, slice_length,
                  burst_left, elapsed_time, dispatch_total, output ready);
endinterface

`default_nettype wire

[rtl/rrs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/rrs_stats.sv]
// Saturating elapsed-time and dispatch counters.
// Depends on rrs_pkg for the update and value structs.
`default_nettype none

module rrs_stats (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rrs_pkg::stats_upd_t upd_i,
  output rrs_pkg::stats_t          stats_o
);
  import rrs_pkg::*;

  logic [SumW-1:0] elapsed_q, elapsed_d;
  logic [SumW-1:0] disp_q, disp_d;
  logic [SumW:0]   elapsed_sum;

  // Saturating accumulate of granted time and dispatch count
  always_comb begin
    elapsed_sum = {1'b0, elapsed_q} + {(SumW + 1 - BurstW)'(0), upd_i.slice};
    elapsed_d   = elapsed_q;
    disp_d      = disp_q;
    if (upd_i.dispatch) begin
      elapsed_d = elapsed_sum[SumW] ? '1 : elapsed_sum[SumW-1:0];
      disp_d    = (&disp_q) ? disp_q : disp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      disp_q    <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      disp_q    <= disp_d;
    end
  end

  // Values after this cycle, so the result shows the counters after its item
  assign stats_o.elapsed    = elapsed_d;
  assign stats_o.dispatches = disp_d;

`ifndef NO_ASSERTIONS
  // Counters never wrap
  a_elapsed_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> elapsed_q >= $past(elapsed_q))
    else $error("elapsed time counter decreased");

  a_disp_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.dispatch && !(&disp_q) |=> disp_q == $past(disp_q) + 1'b1)
    else $error("dispatch counter missed an increment");

  // Counters hold when nothing is dispatched
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i.dispatch |=> elapsed_q == $past(elapsed_q) && disp_q == $past(disp_q))
    else $error("counters changed without a dispatch");
`endif

endmodule

`default_nettype wire

[rtl/rrs_core.sv]
// Queue sequencer: head/tail/count pointers, read-modify-write of the ready
// queue RAM, slice computation and the result register. Depends on rrs_pkg, rrs_if.
`default_nettype none

module rrs_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rrs_pkg::BurstW-1:0]   cfg_wdata_i,
  rrs_req_if.sink                           req_i,
  rrs_rsp_if.source                         rsp_o,
  output logic                              ram_we_o,
  output logic      [rrs_pkg::AddrW-1:0]    ram_waddr_o,
  output rrs_pkg::entry_t                   ram_wdata_o,
  output logic                              ram_re_o,
  output logic      [rrs_pkg::AddrW-1:0]    ram_raddr_o,
  input  wire logic [rrs_pkg::EntryW-1:0]   ram_rdata_i,
  output rrs_pkg::stats_upd_t               stats_upd_o,
  input  wire rrs_pkg::stats_t              stats_i
);
  import rrs_pkg::*;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [AddrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [BurstW-1:0] quantum_q;
  logic              out_valid_q, out_valid_d;

  logic              in_fire, is_dispatch, q_full, q_empty;
  logic              load;
  status_e           ld_status;
  entry_t            head_entry;
  logic [BurstW-1:0] slice, left;

  // Result register payload
  status_e           status_q;
  logic [IdW-1:0]    gid_q;
  logic [PrioW-1:0]  gprio_q;
  logic [BurstW-1:0] slice_q, left_q;
  logic [SumW-1:0]   elapsed_q, disp_q;

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign in_fire     = req_i.valid && req_i.ready;
  assign is_dispatch = (req_i.func == FuncDispatch);
  assign q_full      = (count_q == CntW'(QueueDepth));
  assign q_empty     = (count_q == '0);

  // Slice and remainder from the head entry read out of the RAM
  assign head_entry = entry_t'(ram_rdata_i);
  assign slice      = (quantum_q < head_entry.burst) ? quantum_q : head_entry.burst;
  assign left       = head_entry.burst - slice;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && is_dispatch && !q_empty) begin
          state_d = S_POP;
        end
      end
      S_POP:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Queue pointers, RAM access and result load
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;
    load        = 1'b0;
    ld_status   = ST_IDLE;
    stats_upd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!is_dispatch) begin
            load = 1'b1;
            if (q_full) begin
              ld_status = ST_FULL;
            end else begin
              ld_status        = ST_ADDED;
              ram_we_o         = 1'b1;
              ram_wdata_o.id    = req_i.task_id;
              ram_wdata_o.prio  = req_i.task_priority;
              ram_wdata_o.burst = req_i.burst_length;
              tail_d           = next_ptr(tail_q);
              count_d          = count_q + 1'b1;
            end
          end else if (q_empty) begin
            load      = 1'b1;
            ld_status = ST_IDLE;
          end else begin
            ram_re_o = 1'b1;
          end
        end
      end
      S_POP: begin
        load                 = 1'b1;
        ld_status            = ST_DISPATCHED;
        head_d               = next_ptr(head_q);
        stats_upd_o.dispatch = 1'b1;
        stats_upd_o.slice    = slice;
        if (left != '0) begin
          // Requeue at the tail; count is unchanged
          ram_we_o          = 1'b1;
          ram_wdata_o.id    = head_entry.id;
          ram_wdata_o.prio  = head_entry.prio;
          ram_wdata_o.burst = left;
          tail_d            = next_ptr(tail_q);
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register handshake
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      quantum_q   <= QuantumReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload, loaded with the item's outcome
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= ld_status;
      gid_q     <= (state_q == S_POP) ? head_entry.id : '0;
      gprio_q   <= (state_q == S_POP) ? head_entry.prio : '0;
      slice_q   <= (state_q == S_POP) ? slice : '0;
      left_q    <= (state_q == S_POP) ? left : '0;
      elapsed_q <= stats_i.elapsed;
      disp_q    <= stats_i.dispatches;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = status_q;
  assign rsp_o.granted_id       = gid_q;
  assign rsp_o.granted_priority = gprio_q;
  assign rsp_o.slice_length     = slice_q;
  assign rsp_o.burst_left       = left_q;
  assign rsp_o.elapsed_time     = elapsed_q;
  assign rsp_o.dispatch_total   = disp_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("ready queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> count_q != '0 && !out_valid_q)
    else $error("pop on empty queue or with result register busy");

  a_pop_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> $past(ram_re_o))
    else $error("pop without a preceding RAM read");
`endif

endmodule

`default_nettype wire

[rtl/round_robin_time_slice_scheduler.sv]
// Top level of the round-robin time-slice scheduler.
// Depends on rrs_pkg, rrs_if, rrs_ram, rrs_stats and rrs_core.
//
// The scheduler keeps a FIFO ready queue of up to QueueDepth tasks in a RAM
// and answers every request item with exactly one result item. An add, a
// refused add and a dispatch on an empty queue load the result register
// directly; a dispatch reads the head entry out of the queue RAM, then in the
// pop state slices it and, if burst remains, writes it back at the tail. A
// new item is taken once the block is back idle and the result register is
// empty or being emptied in the same cycle. The quantum must be written
// through cfg_we_i/cfg_wdata_i only while no item is in flight; the block
// does not enforce it. It resets to 10 and needs no clearing pass.
`default_nettype none

module round_robin_time_slice_scheduler (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rrs_pkg::BurstW-1:0] cfg_wdata_i,
  rrs_req_if.sink                         req_i,
  rrs_rsp_if.source                       rsp_o
);
  import rrs_pkg::*;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  stats_upd_t        stats_upd;
  stats_t            stats;

  // Ready queue storage
  rrs_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Saturating counters
  rrs_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (stats_upd),
    .stats_o (stats)
  );

  // Sequencer and result register
  rrs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .stats_upd_o (stats_upd),
    .stats_i     (stats)
  );

endmodule

`default_nettype wire

[test/round_robin_time_slice_scheduler_checker.sv]
// Scoreboard for the round-robin time-slice scheduler: it watches the request,
// result and quantum ports and keeps its own copy of the ready queue and counters.
// Depends on rrs_pkg and the rrs_req_if / rrs_rsp_if interfaces.
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rrs_pkg::BurstW-1:0] cfg_wdata_i,
  rrs_req_if                         req_i,
  rrs_rsp_if                         rsp_i,
  output int unsigned                errors_o,
  output int unsigned                outstanding_o
);
  import rrs_pkg::*;

  // One result item as the scheduler should report it
  typedef struct packed {
    status_e           status;
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] slice;
    logic [BurstW-1:0] left;
    logic [SumW-1:0]   elapsed;
    logic [SumW-1:0]   dispatches;
  } grant_t;

  // Shadow scheduler state
  entry_t            ready_slots[QueueDepth];
  int unsigned       slot_head;
  int unsigned       slot_tail;
  int unsigned       slot_count;
  logic [SumW-1:0]   time_total;
  logic [SumW-1:0]   dispatch_count;
  logic [BurstW-1:0] slice_limit;

  grant_t      sched_outcomes[$];
  int unsigned mismatches;

  function automatic void push_slot(input entry_t e);
    ready_slots[slot_tail] = e;
    slot_tail = (slot_tail == QueueDepth - 1) ? 0 : slot_tail + 1;
    slot_count++;
  endfunction

  // Apply one request item to the shadow state and return its result
  function automatic grant_t schedule_item(input logic fn, input logic [IdW-1:0] task_id,
                                           input logic [PrioW-1:0] task_prio,
                                           input logic [BurstW-1:0] task_burst);
    grant_t        g;
    entry_t        head;
    logic [SumW:0] sum;
    g = '0;
    if (fn == FuncAdd) begin
      if (slot_count >= QueueDepth) begin
        g.status = ST_FULL;
      end else begin
        push_slot('{id: task_id, prio: task_prio, burst: task_burst});
        g.status = ST_ADDED;
      end
    end else if (slot_count == 0) begin
      g.status = ST_IDLE;
    end else begin
      head = ready_slots[slot_head];
      slot_head = (slot_head == QueueDepth - 1) ? 0 : slot_head + 1;
      slot_count--;
      g.status = ST_DISPATCHED;
      g.id     = head.id;
      g.prio   = head.prio;
      g.slice  = (slice_limit < head.burst) ? slice_limit : head.burst;
      g.left   = head.burst - g.slice;
      // pop and push in one step, so the requeue always fits
      if (g.left != 0) push_slot('{id: head.id, prio: head.prio, burst: g.left});
      sum = {1'b0, time_total} + g.slice;
      time_total = sum[SumW] ? '1 : sum[SumW-1:0];
      if (dispatch_count != '1) dispatch_count++;
    end
    g.elapsed    = time_total;
    g.dispatches = dispatch_count;
    return g;
  endfunction

  function automatic string grant_text(input grant_t g);
    return $sformatf("status=%0d id=%0d prio=%0d slice=%0d left=%0d elapsed=%0d count=%0d",
                     g.status, g.id, g.prio, g.slice, g.left, g.elapsed, g.dispatches);
  endfunction

  // Sample both channels at each edge; results are checked before new items land
  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t seen;
    grant_t due;
    if (!rst_ni) begin
      slot_head      = 0;
      slot_tail      = 0;
      slot_count     = 0;
      time_total     = '0;
      dispatch_count = '0;
      slice_limit    = QuantumReset;
      mismatches     = 0;
      sched_outcomes.delete();
      errors_o      <= 0;
      outstanding_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        seen.status     = status_e'(rsp_i.status);
        seen.id         = rsp_i.granted_id;
        seen.prio       = rsp_i.granted_priority;
        seen.slice      = rsp_i.slice_length;
        seen.left       = rsp_i.burst_left;
        seen.elapsed    = rsp_i.elapsed_time;
        seen.dispatches = rsp_i.dispatch_total;
        if (sched_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no item pending: %s", $realtime, grant_text(seen));
          mismatches++;
        end else begin
          due = sched_outcomes.pop_front();
          if (seen !== due) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected %s", grant_text(due));
              $display("  actual   %s", grant_text(seen));
            end
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        sched_outcomes.push_back(schedule_item(req_i.func, req_i.task_id,
                                               req_i.task_priority, req_i.burst_length));
      if (cfg_we_i) slice_limit = cfg_wdata_i;
      errors_o      <= mismatches;
      outstanding_o <= sched_outcomes.size();
    end
  end

endmodule

[test/round_robin_time_slice_scheduler_test.sv]
// Top of the scheduler testbench: clock, reset, request and quantum stimulus,
// result-side stalls and the verdict. Depends on rrs_pkg, rrs_if, the block
// and round_robin_time_slice_scheduler_checker.
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_test;
  import rrs_pkg::*;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_CLOGGED
  } rx_mode_e;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BurstW-1:0] cfg_wdata;
  int unsigned       errors;
  int unsigned       outstanding;

  // hurry: no sender gaps and no result stalls
  logic              hurry = 1'b0;
  logic [BurstW-1:0] quantum_now = QuantumReset;
  int unsigned       run_left = 0;
  rx_mode_e          stall_mode = RX_STEADY;
  int unsigned       stall_left = 0;

  rrs_req_if req_ch ();
  rrs_rsp_if rsp_ch ();

  round_robin_time_slice_scheduler dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  round_robin_time_slice_scheduler_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: the stall pattern is redrawn at random each time its hold counter runs out
  always @(posedge clk) begin
    if (hurry) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= rx_mode_e'($urandom_range(0, 2));
        stall_left <= $urandom_range(16, 160);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        RX_STEADY:  rsp_ch.ready <= 1'b1;
        RX_CHOPPY:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default:    rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Bursts cluster around the quantum edges, with the field extremes mixed in
  function automatic logic [BurstW-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return quantum_now;
      3:       return quantum_now + 1'b1;
      4:       return quantum_now - 1'b1;
      5, 6:    return BurstW'($urandom_range(1, 40));
      default: return BurstW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Present one item, with an occasional gap between bursts; returns at its accept edge
  task automatic send_item(input logic fn, input logic [IdW-1:0] id,
                           input logic [PrioW-1:0] prio, input logic [BurstW-1:0] burst);
    int unsigned gap;
    gap = 0;
    if (!hurry) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      run_left--;
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.func          <= fn;
    req_ch.task_id       <= id;
    req_ch.task_priority <= prio;
    req_ch.burst_length  <= burst;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Dispatch items carry random junk in the ignored fields
  task automatic send_dispatch();
    send_item(FuncDispatch, IdW'($urandom_range(0, 255)), PrioW'($urandom_range(0, 15)),
              BurstW'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_add();
    send_item(FuncAdd, IdW'($urandom_range(0, 255)), PrioW'($urandom_range(0, 15)),
              pick_burst());
  endtask

  // Quantum change only once the block has drained
  task automatic set_quantum(input logic [BurstW-1:0] q);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we      <= 1'b0;
    quantum_now = q;
  endtask

  // Add-heavy, balanced, then dispatch-heavy so the queue fills and drains
  task automatic run_mix(input int unsigned n);
    int unsigned add_pct;
    for (int unsigned i = 0; i < n; i++) begin
      add_pct = (i < n / 3) ? 75 : (i < 2 * n / 3) ? 50 : 25;
      if ($urandom_range(0, 99) < add_pct) send_random_add();
      else send_dispatch();
    end
  endtask

  initial begin : stimulus
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.func          = FuncAdd;
    req_ch.task_id       = '0;
    req_ch.task_priority = '0;
    req_ch.burst_length  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset quantum of 10
    send_dispatch();                                  // empty queue
    send_item(FuncAdd, '0, '0, '0);                   // zero burst
    send_item(FuncAdd, '1, '1, '1);                   // field maxima
    send_item(FuncAdd, 8'hA5, 4'h5, BurstW'(10));     // burst equal to quantum
    send_item(FuncAdd, 8'h5A, 4'hA, BurstW'(11));     // one unit over
    repeat (4) send_dispatch();
    repeat (14) send_random_add();                    // queue reaches full
    send_random_add();                                // refused
    send_dispatch();                                  // requeue while full

    // Random phases over several quanta, including both ends and zero
    set_quantum(BurstW'(1));
    run_mix(250);
    set_quantum('1);
    run_mix(250);
    set_quantum('0);
    run_mix(60);
    set_quantum(BurstW'($urandom_range(2, 40)));
    run_mix(300);
    set_quantum(BurstW'($urandom_range(41, 65534)));
    run_mix(250);
    set_quantum(BurstW'(10));
    run_mix(250);

    // Back-to-back items with the result side always ready
    hurry <= 1'b1;
    run_mix(100);
    hurry <= 1'b0;
    set_quantum(BurstW'($urandom_range(1, 65535)));
    run_mix(100);

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
